### rtl/bc_pkg.sv
// bc_pkg: widths, constants and the item record that moves along the divider cells
// no dependencies
package bc_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int ProdW  = 34;
  localparam int SumW   = 35;
  localparam int FracW  = 16;
  localparam int DvdW   = SumW + FracW + 2;     // n*2^17 + d
  localparam int DivW   = SumW + 1;            // 2*d
  localparam int QuoW   = DvdW;
  localparam int WtW    = 19;
  localparam int GamW   = QuoW + 3;

  localparam logic signed [WtW-1:0] WtMax = WtW'(262143);
  localparam logic signed [WtW-1:0] WtMin = -WtW'(262144);
  localparam logic signed [GamW-1:0] WtOne = GamW'(65536);

  // one quotient lane of the restoring divider
  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [DvdW-1:0] dvd;
    logic [QuoW-1:0] quo;
    logic            neg;
  } bc_lane_t;

  // transaction record handed from cell to cell
  typedef struct packed {
    bc_lane_t        la;
    bc_lane_t        lb;
    logic [DivW-1:0] dsr;
    logic            degen;
  } bc_item_t;

endpackage

### rtl/bc_front.sv
// bc_front: edge differences, cross products, sums and divider setup
// depends on bc_pkg
module bc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_ok,
  input  logic signed [bc_pkg::CoordW-1:0]  px,
  input  logic signed [bc_pkg::CoordW-1:0]  py,
  input  logic signed [bc_pkg::CoordW-1:0]  ax,
  input  logic signed [bc_pkg::CoordW-1:0]  ay,
  input  logic signed [bc_pkg::CoordW-1:0]  bx,
  input  logic signed [bc_pkg::CoordW-1:0]  by,
  input  logic signed [bc_pkg::CoordW-1:0]  cx,
  input  logic signed [bc_pkg::CoordW-1:0]  cy,
  output logic                              item_ok,
  output bc_pkg::bc_item_t                  item
);

  localparam int DiffW = bc_pkg::DiffW;
  localparam int SumW  = bc_pkg::SumW;

  logic signed [bc_pkg::DiffW-1:0] d [10];
  logic signed [bc_pkg::ProdW-1:0] p [6];
  logic signed [bc_pkg::SumW-1:0]  den, na, nb;
  logic [2:0]                      vld;
  logic [bc_pkg::SumW-1:0]         ua, ub, ud;
  bc_pkg::bc_item_t                item_next;

  // absolute values and divider operands
  always_comb begin
    ua = na[bc_pkg::SumW-1] ? bc_pkg::SumW'(-na) : bc_pkg::SumW'(na);
    ub = nb[bc_pkg::SumW-1] ? bc_pkg::SumW'(-nb) : bc_pkg::SumW'(nb);
    ud = den[bc_pkg::SumW-1] ? bc_pkg::SumW'(-den) : bc_pkg::SumW'(den);
    item_next.dsr    = {ud, 1'b0};
    item_next.degen  = (den == '0);
    item_next.la.rem = '0;
    item_next.la.quo = '0;
    item_next.la.dvd = {1'b0, ua, {(bc_pkg::FracW + 1){1'b0}}} + bc_pkg::DvdW'(ud);
    item_next.la.neg = na[bc_pkg::SumW-1] ^ den[bc_pkg::SumW-1];
    item_next.lb.rem = '0;
    item_next.lb.quo = '0;
    item_next.lb.dvd = {1'b0, ub, {(bc_pkg::FracW + 1){1'b0}}} + bc_pkg::DvdW'(ud);
    item_next.lb.neg = nb[bc_pkg::SumW-1] ^ den[bc_pkg::SumW-1];
  end

  // four register stages
  always_ff @(posedge clk) begin
    if (en) begin
      d[0] <= DiffW'(ax) - DiffW'(bx);
      d[1] <= DiffW'(cy) - DiffW'(by);
      d[2] <= DiffW'(ay) - DiffW'(by);
      d[3] <= DiffW'(cx) - DiffW'(bx);
      d[4] <= DiffW'(px) - DiffW'(bx);
      d[5] <= DiffW'(py) - DiffW'(by);
      d[6] <= DiffW'(px) - DiffW'(cx);
      d[7] <= DiffW'(ay) - DiffW'(cy);
      d[8] <= DiffW'(py) - DiffW'(cy);
      d[9] <= DiffW'(ax) - DiffW'(cx);
      p[0] <= d[0] * d[1];
      p[1] <= d[2] * d[3];
      p[2] <= d[4] * d[1];
      p[3] <= d[5] * d[3];
      p[4] <= d[6] * d[7];
      p[5] <= d[8] * d[9];
      den  <= SumW'(p[1]) - SumW'(p[0]);
      na   <= SumW'(p[3]) - SumW'(p[2]);
      nb   <= SumW'(p[5]) - SumW'(p[4]);
      item <= item_next;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      item_ok <= 1'b0;
    end else if (en) begin
      vld     <= {vld[1:0], in_ok};
      item_ok <= vld[2];
    end
  end

endmodule

### rtl/bc_cell.sv
// bc_cell: one restoring-division step for both weight lanes
// depends on bc_pkg
module bc_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_ok,
  input  bc_pkg::bc_item_t  din,
  output logic              out_ok,
  output bc_pkg::bc_item_t  dout
);

  bc_pkg::bc_item_t dout_next;
  logic [bc_pkg::DivW:0] ra, rb;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    dout_next = din;
    ra = {din.la.rem, din.la.dvd[bc_pkg::DvdW-1]};
    rb = {din.lb.rem, din.lb.dvd[bc_pkg::DvdW-1]};
    dout_next.la.dvd = {din.la.dvd[bc_pkg::DvdW-2:0], 1'b0};
    dout_next.lb.dvd = {din.lb.dvd[bc_pkg::DvdW-2:0], 1'b0};
    if (ra >= {1'b0, din.dsr}) begin
      dout_next.la.rem = bc_pkg::DivW'(ra - {1'b0, din.dsr});
      dout_next.la.quo = {din.la.quo[bc_pkg::QuoW-2:0], 1'b1};
    end else begin
      dout_next.la.rem = bc_pkg::DivW'(ra);
      dout_next.la.quo = {din.la.quo[bc_pkg::QuoW-2:0], 1'b0};
    end
    if (rb >= {1'b0, din.dsr}) begin
      dout_next.lb.rem = bc_pkg::DivW'(rb - {1'b0, din.dsr});
      dout_next.lb.quo = {din.lb.quo[bc_pkg::QuoW-2:0], 1'b1};
    end else begin
      dout_next.lb.rem = bc_pkg::DivW'(rb);
      dout_next.lb.quo = {din.lb.quo[bc_pkg::QuoW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ok <= 1'b0;
    end else if (en) begin
      out_ok <= in_ok;
    end
  end

endmodule

### rtl/barycentric_coordinates.sv
// barycentric_coordinates: pipelined barycentric weights of a point in a 2D triangle
// depends on bc_pkg, bc_front, bc_cell
//
//   channel  handshake            payload
//   input    in_valid / in_stall  point_*, vertex_{a,b,c}_{x,y}  (Q12.4)
//   output   out_valid/ out_stall alpha, beta, gamma (Q3.16), degenerate
//
// one transaction per cycle unless held; pipe of 4 front stages, 53 divider cells
// and 1 output stage, the cells set by the one-bit-per-cell restoring divider chain
// rst is synchronous and clears only the valid bits of every stage
// the whole pipe holds while the output register is full and out_stall is high;
// in_stall follows that same hold
module barycentric_coordinates (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [bc_pkg::CoordW-1:0] point_x,
  input  logic signed [bc_pkg::CoordW-1:0] point_y,
  input  logic signed [bc_pkg::CoordW-1:0] vertex_a_x,
  input  logic signed [bc_pkg::CoordW-1:0] vertex_a_y,
  input  logic signed [bc_pkg::CoordW-1:0] vertex_b_x,
  input  logic signed [bc_pkg::CoordW-1:0] vertex_b_y,
  input  logic signed [bc_pkg::CoordW-1:0] vertex_c_x,
  input  logic signed [bc_pkg::CoordW-1:0] vertex_c_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [bc_pkg::WtW-1:0]    alpha,
  output logic signed [bc_pkg::WtW-1:0]    beta,
  output logic signed [bc_pkg::WtW-1:0]    gamma,
  output logic                             degenerate
);

  localparam int NCell = bc_pkg::QuoW;

  logic                              en;
  logic                              ok [NCell+1];
  bc_pkg::bc_item_t                  chain [NCell+1];
  logic signed [bc_pkg::GamW-1:0]    qa, qb, qc;
  logic signed [bc_pkg::WtW-1:0]     alpha_next, beta_next, gamma_next;

  // global advance
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  bc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ok   (in_valid),
    .px      (point_x),
    .py      (point_y),
    .ax      (vertex_a_x),
    .ay      (vertex_a_y),
    .bx      (vertex_b_x),
    .by      (vertex_b_y),
    .cx      (vertex_c_x),
    .cy      (vertex_c_y),
    .item_ok (ok[0]),
    .item    (chain[0])
  );

  // divider cells, one quotient bit each
  for (genvar i = 0; i < NCell; i++) begin : g_cell
    bc_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .in_ok  (ok[i]),
      .din    (chain[i]),
      .out_ok (ok[i+1]),
      .dout   (chain[i+1])
    );
  end

  function automatic logic signed [bc_pkg::WtW-1:0] sat(
    input logic signed [bc_pkg::GamW-1:0] v
  );
    if (v > bc_pkg::GamW'(bc_pkg::WtMax)) begin
      return bc_pkg::WtMax;
    end else if (v < bc_pkg::GamW'(bc_pkg::WtMin)) begin
      return bc_pkg::WtMin;
    end
    return bc_pkg::WtW'(v);
  endfunction

  // sign, gamma and saturation
  always_comb begin
    qa = chain[NCell].la.neg ? -bc_pkg::GamW'(chain[NCell].la.quo)
                             :  bc_pkg::GamW'(chain[NCell].la.quo);
    qb = chain[NCell].lb.neg ? -bc_pkg::GamW'(chain[NCell].lb.quo)
                             :  bc_pkg::GamW'(chain[NCell].lb.quo);
    qc = bc_pkg::WtOne - qa - qb;
    if (chain[NCell].degen) begin
      alpha_next = '0;
      beta_next  = '0;
      gamma_next = '0;
    end else begin
      alpha_next = sat(qa);
      beta_next  = sat(qb);
      gamma_next = sat(qc);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      alpha      <= alpha_next;
      beta       <= beta_next;
      gamma      <= gamma_next;
      degenerate <= chain[NCell].degen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ok[NCell];
    end
  end

endmodule

### test/tb_top.sv
// tb_top: self-checking testbench for barycentric_coordinates
// drives random and directed triangles, predicts weights, checks them in order
// depends on bc_pkg and the barycentric_coordinates rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [bc_pkg::WtW-1:0] alpha;
    logic signed [bc_pkg::WtW-1:0] beta;
    logic signed [bc_pkg::WtW-1:0] gamma;
    logic                          degenerate;
  } weights_t;

  // scoreboard of predicted weights
  class weight_board;
    weights_t pending[$];
    int       errors;

    function longint div_round(longint n, longint d);
      bit     neg;
      longint un, ud, q;
      neg = (n < 0) != (d < 0);
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = ((un <<< 17) + ud) / (ud <<< 1);
      return neg ? -q : q;
    endfunction

    function logic signed [bc_pkg::WtW-1:0] clamp(longint v);
      if (v > 262143) v = 262143;
      if (v < -262144) v = -262144;
      return v[bc_pkg::WtW-1:0];
    endfunction

    function void note_input(logic signed [15:0] c[8]);
      longint   px, py, ax, ay, bx, by, cx, cy, den, na, nb, qa, qb;
      weights_t w;
      px = c[0]; py = c[1]; ax = c[2]; ay = c[3];
      bx = c[4]; by = c[5]; cx = c[6]; cy = c[7];
      den = -(ax - bx) * (cy - by) + (ay - by) * (cx - bx);
      na = -(px - bx) * (cy - by) + (py - by) * (cx - bx);
      nb = -(px - cx) * (ay - cy) + (py - cy) * (ax - cx);
      if (den == 0) begin
        w = '{'0, '0, '0, 1'b1};
      end else begin
        qa = div_round(na, den);
        qb = div_round(nb, den);
        w = '{clamp(qa), clamp(qb), clamp(65536 - qa - qb), 1'b0};
      end
      pending.push_back(w);
    endfunction

    function void check_result(weights_t got);
      weights_t exp_w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result a=%0d", got.alpha);
        return;
      end
      exp_w = pending.pop_front();
      if (got.alpha !== exp_w.alpha || got.beta !== exp_w.beta ||
          got.gamma !== exp_w.gamma || got.degenerate !== exp_w.degenerate) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp a=%0d b=%0d g=%0d d=%0b got a=%0d b=%0d g=%0d d=%0b",
                   exp_w.alpha, exp_w.beta, exp_w.gamma, exp_w.degenerate,
                   got.alpha, got.beta, got.gamma, got.degenerate);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, degenerate;
  logic signed [bc_pkg::CoordW-1:0] coord[8] = '{default: '0};
  logic signed [bc_pkg::WtW-1:0] alpha, beta, gamma;
  weight_board board = new();
  int  cycles = 0;
  bit  stim_done = 1'b0;

  always #4 clk = ~clk;

  barycentric_coordinates u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .point_x(coord[0]), .point_y(coord[1]),
    .vertex_a_x(coord[2]), .vertex_a_y(coord[3]),
    .vertex_b_x(coord[4]), .vertex_b_y(coord[5]),
    .vertex_c_x(coord[6]), .vertex_c_y(coord[7]),
    .out_valid(out_valid), .out_stall(out_stall),
    .alpha(alpha), .beta(beta), .gamma(gamma), .degenerate(degenerate)
  );

  // offer one transaction, wait for acceptance, then drop in_valid and idle if gap is nonzero
  task automatic send_triangle(logic signed [15:0] c[8], int gap);
    for (int i = 0; i < 8; i++) coord[i] <= c[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_input(c);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_coord(int mode);
    unique case (mode)
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 255)) - 16'sd128;
      2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(0, 4095)) - 16'sd2048;
    endcase
  endfunction

  // sender: directed part, then random triangles
  initial begin
    logic signed [15:0] c[8];
    int mode, gap;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // extremes of every coordinate
    c = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh8000, 16'sh7fff};
    send_triangle(c, 0);
    c = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh7fff, 16'sh8000};
    send_triangle(c, 1);
    // degenerate: all vertices equal, and collinear
    c = '{16'sd5, 16'sd7, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3};
    send_triangle(c, 0);
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd32, 16'sd32};
    send_triangle(c, 0);
    // point at vertices, near the centroid, outside, tiny triangle (saturation)
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16};
    send_triangle(c, 0);
    c = '{16'sd16, 16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16};
    send_triangle(c, 0);
    c = '{16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16};
    send_triangle(c, 2);
    c = '{16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1};
    send_triangle(c, 0);
    c = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1};
    send_triangle(c, 0);
    c = '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd2, 16'sd0};
    send_triangle(c, 0);
    c = '{-16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd3, -16'sd2, 16'sd0};
    send_triangle(c, 0);
    for (int n = 0; n < 400; n++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 8; i++) c[i] = rand_coord(mode);
      if ($urandom_range(0, 15) == 0) begin
        c[4] = c[2]; c[5] = c[3];
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (n > 100 && n < 200) gap = 0;
      send_triangle(c, gap);
      // pause until the pipe drains once
      if (n == 250) begin
        in_valid <= 1'b0;
        wait (board.pending.size() == 0);
        @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random wait per transaction, with one long hold-off
  initial begin
    int wait_c;
    bit long_done;
    long_done = 1'b0;
    @(negedge rst);
    forever begin
      if (!long_done && cycles >= 1000) begin
        long_done = 1'b1;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
      end else begin
        wait_c = $urandom_range(0, 16);
        if (wait_c > 0) begin
          out_stall <= 1'b1;
          repeat (wait_c) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // check every accepted result
  always @(posedge clk) begin
    weights_t got;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      got = '{alpha, beta, gamma, degenerate};
      board.check_result(got);
    end
  end

  // end of run and timeout
  initial begin
    wait (stim_done && board.pending.size() == 0);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    wait (cycles == 200000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule

### filelist.f
rtl/bc_pkg.sv
rtl/bc_front.sv
rtl/bc_cell.sv
rtl/barycentric_coordinates.sv
test/tb_top.sv
